### rtl/slap_pkg.sv
// Shared types and constants for the stopwatch with lap memory and alert.
// No dependencies; every other file of the block imports this package.
package slap_pkg;

    localparam int TIME_W = 29;
    localparam int LAPS_W = 16;
    localparam int ELAPSED_W = 10;

    localparam logic [TIME_W-1:0] MS_HOUR     = TIME_W'(60 * 60 * 1000);
    localparam logic [TIME_W-1:0] MS_MINUTE   = TIME_W'(60 * 1000);
    localparam logic [TIME_W-1:0] MS_SECOND   = TIME_W'(1 * 1000);
    localparam logic [TIME_W-1:0] ALERT_MAX   = TIME_W'(99 * 1000 * 3600);
    localparam logic [TIME_W-1:0] ALERT_RESET = TIME_W'(25 * 1000);
    localparam logic [TIME_W-1:0] TIME_MAX    = TIME_W'(359999999);
    localparam logic [LAPS_W-1:0] LAPS_MAX    = '1;

    typedef enum logic [2:0] {
        KIND_TICK        = 3'd0,
        KIND_START_STOP  = 3'd1,
        KIND_RESET       = 3'd2,
        KIND_LAP         = 3'd3,
        KIND_SCROLL_DOWN = 3'd4,
        KIND_SCROLL_UP   = 3'd5,
        KIND_ALERT_ADJ   = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        UNIT_HOUR   = 2'd0,
        UNIT_MINUTE = 2'd1,
        UNIT_SECOND = 2'd2
    } unit_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_CAP  = 1'b1
    } state_t;

    // Watch status after an event, passed from control to the top level.
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              running;
        logic              alert_fire;
        logic [TIME_W-1:0] alert_ms;
        logic [LAPS_W-1:0] laps_taken;
        logic              view_valid;
        logic [LAPS_W-1:0] view_lap_number;
    } watch_t;

endpackage

### rtl/slap_if.sv
// Valid/ready channel interfaces for events in and results out.
// Depends on slap_pkg for field widths.
interface slap_evt_if;
    import slap_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           kind;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic [1:0]           adjust_unit;
    logic                 adjust_down;

    modport source (output valid, kind, elapsed_ms, adjust_unit, adjust_down, input ready);
    modport sink (input valid, kind, elapsed_ms, adjust_unit, adjust_down, output ready);
endinterface

interface slap_res_if;
    import slap_pkg::*;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_ms;
    logic              running;
    logic              alert_fire;
    logic [TIME_W-1:0] alert_ms;
    logic [LAPS_W-1:0] laps_taken;
    logic [LAPS_W-1:0] view_lap_number;
    logic [TIME_W-1:0] view_lap_ms;

    modport source (output valid, time_ms, running, alert_fire, alert_ms, laps_taken,
                    view_lap_number, view_lap_ms, input ready);
    modport sink (input valid, time_ms, running, alert_fire, alert_ms, laps_taken,
                  view_lap_number, view_lap_ms, output ready);
endinterface

### rtl/slap_ctrl.sv
// Event decode and watch state: time, run flag, alert, lap counters, view offset.
// Depends on slap_pkg.
module slap_ctrl #(
    parameter int LAP_DEPTH = 16,
    parameter int VIEW_ROWS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic [2:0]                       kind,
    input  logic [slap_pkg::ELAPSED_W-1:0]   elapsed_ms,
    input  logic [1:0]                       adjust_unit,
    input  logic                             adjust_down,
    output logic                             push,
    output logic [slap_pkg::TIME_W-1:0]      push_data,
    output logic [$clog2(LAP_DEPTH)-1:0]     off_next,
    output slap_pkg::watch_t                 status
);
    import slap_pkg::*;

    localparam int AW = $clog2(LAP_DEPTH);
    localparam int CW = AW + 8;
    localparam logic [AW-1:0] FILL_MAX = AW'(LAP_DEPTH - 1);

    logic [TIME_W-1:0] time_reg, time_next;
    logic              run_reg, run_next;
    logic [TIME_W-1:0] alert_reg, alert_next;
    logic              armed_reg, armed_next;
    logic [AW-1:0]     fill_reg, fill_next;
    logic [LAPS_W-1:0] total_reg, total_next;
    logic [AW-1:0]     off_reg;
    logic              fire_reg;

    logic              armed_upd;
    logic              fire;
    logic [TIME_W:0]   tick_sum;
    logic [TIME_W:0]   adj_sum;
    logic [TIME_W-1:0] step;
    logic              step_ok;

    assign tick_sum = {1'b0, time_reg} + (TIME_W+1)'(elapsed_ms);
    assign adj_sum  = {1'b0, alert_reg} + {1'b0, step};

    always_comb
    begin
        step    = MS_SECOND;
        step_ok = 1'b1;
        unique case (unit_t'(adjust_unit))
            UNIT_HOUR:   step = MS_HOUR;
            UNIT_MINUTE: step = MS_MINUTE;
            UNIT_SECOND: step = MS_SECOND;
            default:     step_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        time_next  = time_reg;
        run_next   = run_reg;
        alert_next = alert_reg;
        armed_upd  = armed_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        off_next   = off_reg;
        push       = 1'b0;
        if (go)
        begin
            unique case (kind_t'(kind))
                KIND_TICK:
                begin
                    if (run_reg)
                        time_next = (tick_sum > {1'b0, TIME_MAX}) ? TIME_MAX
                                                                 : tick_sum[TIME_W-1:0];
                end
                KIND_START_STOP: run_next = !run_reg;
                KIND_RESET:
                begin
                    time_next  = '0;
                    run_next   = 1'b0;
                    fill_next  = '0;
                    total_next = '0;
                    off_next   = '0;
                    armed_upd  = 1'b1;
                end
                KIND_LAP:
                begin
                    push = 1'b1;
                    if (total_reg != LAPS_MAX)
                        total_next = total_reg + 1'b1;
                    if (fill_reg != FILL_MAX)
                        fill_next = fill_reg + 1'b1;
                    off_next = '0;
                end
                KIND_SCROLL_DOWN:
                begin
                    if (off_reg != '0)
                        off_next = off_reg - 1'b1;
                end
                KIND_SCROLL_UP:
                begin
                    if ((CW'(off_reg) + CW'(VIEW_ROWS)) <= CW'(fill_reg))
                        off_next = off_reg + 1'b1;
                end
                KIND_ALERT_ADJ:
                begin
                    if (step_ok)
                    begin
                        armed_upd = 1'b1;
                        if (adjust_down)
                            alert_next = (step > alert_reg) ? '0 : alert_reg - step;
                        else
                            alert_next = (adj_sum > {1'b0, ALERT_MAX}) ? '0
                                                                      : adj_sum[TIME_W-1:0];
                    end
                end
                default: ;
            endcase
        end
        // alert compare sees the state after the event
        fire       = go && armed_upd && (time_next > alert_next);
        armed_next = armed_upd && !fire;
    end

    assign push_data = time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            run_reg   <= 1'b0;
            alert_reg <= ALERT_RESET;
            armed_reg <= 1'b1;
            fill_reg  <= '0;
            total_reg <= '0;
            off_reg   <= '0;
            fire_reg  <= 1'b0;
        end
        else
        begin
            time_reg  <= time_next;
            run_reg   <= run_next;
            alert_reg <= alert_next;
            armed_reg <= armed_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            off_reg   <= off_next;
            if (go)
                fire_reg <= fire;
        end
    end

    always_comb
    begin
        status.time_ms         = time_reg;
        status.running         = run_reg;
        status.alert_fire      = fire_reg;
        status.alert_ms        = alert_reg;
        status.laps_taken      = total_reg;
        status.view_valid      = total_reg > LAPS_W'(off_reg);
        status.view_lap_number = status.view_valid ? total_reg - LAPS_W'(off_reg) : '0;
    end

endmodule

### rtl/slap_lap_mem.sv
// Lap history as a circular buffer in a synchronous RAM, newest entry at head.
// Depends on slap_pkg. Read data is registered on go and arrives in the cycle after it.
module slap_lap_mem #(
    parameter int LAP_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic                          push,
    input  logic [slap_pkg::TIME_W-1:0]   push_data,
    input  logic [$clog2(LAP_DEPTH)-1:0]  off_next,
    output logic [slap_pkg::TIME_W-1:0]   view_ms
);
    import slap_pkg::*;

    localparam int AW = $clog2(LAP_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(LAP_DEPTH - 1);

    logic [TIME_W-1:0] mem [LAP_DEPTH];
    logic [AW-1:0]     head_reg, head_next;
    logic [AW:0]       addr_wide;
    logic [AW-1:0]     rd_addr;
    logic [TIME_W-1:0] rdata_reg;
    logic              fwd_reg;
    logic [TIME_W-1:0] fwd_data_reg;

    always_comb
    begin
        head_next = head_reg;
        if (push)
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    end

    // entry k back from head, modulo the depth
    always_comb
    begin
        addr_wide = (AW+1)'(head_next) + (AW+1)'(LAP_DEPTH) - (AW+1)'(off_next);
        if (addr_wide >= (AW+1)'(LAP_DEPTH))
            addr_wide = addr_wide - (AW+1)'(LAP_DEPTH);
        rd_addr = addr_wide[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_reg <= '0;
        else
            head_reg <= head_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[head_next] <= push_data;
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_reg      <= push;
            fwd_data_reg <= push_data;
        end
    end

    // a lap resets the view to the entry just written: bypass the RAM
    assign view_ms = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

### rtl/stopwatch_lap_alert.sv
// Each event passes through ST_IDLE and ST_CAP: the accept cycle applies it to the
// watch state and issues the lap RAM read (with bypass of a lap written in that
// cycle), and ST_CAP loads the result register once it is free. A new event is
// accepted once the result register has been loaded, so the block takes no new
// event before the last one is through; a stalled result waits in the register
// while the next event is applied. The lap RAM needs no clearing after reset:
// laps not taken since the last reset are never shown.
// Depends on slap_pkg, slap_if, slap_ctrl and slap_lap_mem.
module stopwatch_lap_alert #(
    parameter int LAP_DEPTH = 16,
    parameter int VIEW_ROWS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    slap_evt_if.sink    events,
    slap_res_if.source  results
);
    import slap_pkg::*;

    localparam int AW = $clog2(LAP_DEPTH);

    state_t            state_reg, state_next;
    logic              go;
    logic              load;
    logic              out_free;
    logic              push;
    logic [TIME_W-1:0] push_data;
    logic [AW-1:0]     off_next;
    watch_t            status;
    logic [TIME_W-1:0] view_ms;

    logic              out_valid_reg;
    logic [TIME_W-1:0] time_reg;
    logic              running_reg;
    logic              fire_reg;
    logic [TIME_W-1:0] alert_reg;
    logic [LAPS_W-1:0] laps_reg;
    logic [LAPS_W-1:0] vnum_reg;
    logic [TIME_W-1:0] vms_reg;

    assign out_free = !out_valid_reg || results.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (events.valid) state_next = ST_CAP;
            ST_CAP:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        events.ready = 1'b0;
        load         = 1'b0;
        unique case (state_reg)
            ST_IDLE: events.ready = 1'b1;
            ST_CAP:  load = out_free;
            default: ;
        endcase
    end

    assign go = events.valid && events.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    slap_ctrl #(
        .LAP_DEPTH (LAP_DEPTH),
        .VIEW_ROWS (VIEW_ROWS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .kind        (events.kind),
        .elapsed_ms  (events.elapsed_ms),
        .adjust_unit (events.adjust_unit),
        .adjust_down (events.adjust_down),
        .push        (push),
        .push_data   (push_data),
        .off_next    (off_next),
        .status      (status)
    );

    slap_lap_mem #(
        .LAP_DEPTH (LAP_DEPTH)
    ) u_lap_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .push      (push),
        .push_data (push_data),
        .off_next  (off_next),
        .view_ms   (view_ms)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            time_reg    <= status.time_ms;
            running_reg <= status.running;
            fire_reg    <= status.alert_fire;
            alert_reg   <= status.alert_ms;
            laps_reg    <= status.laps_taken;
            vnum_reg    <= status.view_lap_number;
            vms_reg     <= status.view_valid ? view_ms : '0;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.time_ms         = time_reg;
    assign results.running         = running_reg;
    assign results.alert_fire      = fire_reg;
    assign results.alert_ms        = alert_reg;
    assign results.laps_taken      = laps_reg;
    assign results.view_lap_number = vnum_reg;
    assign results.view_lap_ms     = vms_reg;

    a_accept_to_cap: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> state_reg == ST_CAP)
        else $error("accepted event did not move to capture");

    a_no_accept_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CAP |-> !events.ready)
        else $error("event accepted while previous one is in flight");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("result register load lost");

    a_fire_means_past: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.alert_fire |-> results.time_ms > results.alert_ms)
        else $error("alert fired with time not past alert");

endmodule

### bench/tb_stopwatch_lap_alert.sv
`timescale 1ns / 1ps
// Self-checking bench for stopwatch_lap_alert: drives watch events, checks each status result.
// Depends on slap_pkg, slap_if (slap_evt_if, slap_res_if) and the block's RTL.
module tb_stopwatch_lap_alert;
    import slap_pkg::*;

    localparam int LAP_DEPTH = 16;
    localparam int VIEW_ROWS = 6;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 400;
    localparam int PRINT_MAX = 20;
    localparam int HOLD_AT = 120;
    localparam int HOLD_CYCLES = 400;

    // codes the package leaves unnamed
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam logic [1:0] UNIT_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]           kind;
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic [1:0]           adjust_unit;
        logic                 adjust_down;
    } watch_event_t;

    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              running;
        logic              alert_fire;
        logic [TIME_W-1:0] alert_ms;
        logic [LAPS_W-1:0] laps_taken;
        logic [LAPS_W-1:0] view_lap_number;
        logic [TIME_W-1:0] view_lap_ms;
    } watch_status_t;

    class lap_watch_board;
        logic [TIME_W-1:0] total;
        bit                counting;
        logic [TIME_W-1:0] alert_at;
        bit                armed;
        logic [TIME_W-1:0] laps [LAP_DEPTH];
        int unsigned       fill;
        int unsigned       lap_count;
        int unsigned       offset;
        watch_status_t     expected_status [$];
        int                errors;

        function new();
            alert_at = ALERT_RESET;
            errors = 0;
            clear_watch();
        endfunction

        function void clear_watch();
            total = '0;
            counting = 1'b0;
            foreach (laps[i]) laps[i] = '0;
            fill = 0;
            lap_count = 0;
            offset = 0;
            armed = 1'b1;
        endfunction

        function void note_event(watch_event_t e);
            watch_status_t s;
            longint sum;
            longint step;
            int i;
            s = '0;
            case (e.kind)
                KIND_TICK:
                    if (counting) begin
                        sum = longint'(total) + longint'(e.elapsed_ms);
                        total = (sum > longint'(TIME_MAX)) ? TIME_MAX : TIME_W'(sum);
                    end
                KIND_START_STOP: counting = !counting;
                KIND_RESET: clear_watch();
                KIND_LAP:
                begin
                    if (lap_count < LAPS_MAX)
                        lap_count++;
                    if (fill < LAP_DEPTH - 1)
                        fill++;
                    for (i = fill; i > 0; i--)
                        laps[i] = laps[i-1];
                    laps[0] = total;
                    offset = 0;
                end
                KIND_SCROLL_DOWN:
                    if (offset > 0)
                        offset--;
                KIND_SCROLL_UP:
                    if (offset + VIEW_ROWS <= fill)
                        offset++;
                KIND_ALERT_ADJ:
                    if (e.adjust_unit != UNIT_UNUSED) begin
                        case (e.adjust_unit)
                            UNIT_HOUR:   step = longint'(MS_HOUR);
                            UNIT_MINUTE: step = longint'(MS_MINUTE);
                            default:     step = longint'(MS_SECOND);
                        endcase
                        sum = longint'(alert_at) + (e.adjust_down ? -step : step);
                        if (sum < 0 || sum > longint'(ALERT_MAX))
                            sum = 0;
                        alert_at = TIME_W'(sum);
                        armed = 1'b1;
                    end
                default: ;
            endcase
            // alert compare runs after the event is applied
            if (armed && total > alert_at) begin
                s.alert_fire = 1'b1;
                armed = 1'b0;
            end
            if (lap_count > offset && offset < LAP_DEPTH) begin
                s.view_lap_number = LAPS_W'(lap_count - offset);
                s.view_lap_ms = laps[offset];
            end
            s.time_ms = total;
            s.running = counting;
            s.alert_ms = alert_at;
            s.laps_taken = LAPS_W'(lap_count);
            expected_status.push_back(s);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got) begin
                errors++;
                if (errors <= PRINT_MAX)
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, field, want, got);
            end
        endfunction

        function void check_status(watch_status_t got);
            watch_status_t want;
            if (expected_status.size() == 0) begin
                errors++;
                if (errors <= PRINT_MAX)
                    $display("%0t ns: unexpected result, expected none, actual time_ms %0d",
                             $time, got.time_ms);
                return;
            end
            want = expected_status.pop_front();
            compare_field("time_ms", want.time_ms, got.time_ms);
            compare_field("running", want.running, got.running);
            compare_field("alert_fire", want.alert_fire, got.alert_fire);
            compare_field("alert_ms", want.alert_ms, got.alert_ms);
            compare_field("laps_taken", want.laps_taken, got.laps_taken);
            compare_field("view_lap_number", want.view_lap_number, got.view_lap_number);
            compare_field("view_lap_ms", want.view_lap_ms, got.view_lap_ms);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    slap_evt_if evt_ch ();
    slap_res_if res_ch ();

    stopwatch_lap_alert #(
        .LAP_DEPTH(LAP_DEPTH),
        .VIEW_ROWS(VIEW_ROWS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .events(evt_ch),
        .results(res_ch)
    );

    lap_watch_board board = new();
    int random_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;

    always #4 clk = ~clk;

    // transfer monitors, sampled with pre-edge values
    always @(posedge clk) begin
        if (rst_n && evt_ch.valid && evt_ch.ready)
            board.note_event({evt_ch.kind, evt_ch.elapsed_ms, evt_ch.adjust_unit,
                              evt_ch.adjust_down});
    end

    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            board.check_status({res_ch.time_ms, res_ch.running, res_ch.alert_fire,
                                res_ch.alert_ms, res_ch.laps_taken, res_ch.view_lap_number,
                                res_ch.view_lap_ms});
            results_seen++;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off to back up the input
    initial begin
        bit held;
        bit level;
        int span;
        int r;
        held = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            r = $urandom_range(99);
            if (r < 55) begin
                level = 1'b1;
                span = $urandom_range(1, 30);
            end else if (r < 92) begin
                level = 1'b0;
                span = $urandom_range(1, 3);
            end else begin
                level = 1'b0;
                span = $urandom_range(10, 60);
            end
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                level = 1'b0;
                span = HOLD_CYCLES;
            end
            res_ch.ready <= level;
            repeat (span) @(posedge clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    task automatic push_event(input logic [2:0] kind, input int elapsed,
                              input logic [1:0] unit, input bit down);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.kind <= kind;
        evt_ch.elapsed_ms <= ELAPSED_W'(elapsed);
        evt_ch.adjust_unit <= unit;
        evt_ch.adjust_down <= down;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        random_sent++;
    endtask

    task automatic push_noise();
        push_event(3'($urandom_range(0, 7)), $urandom_range(0, 1023),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic push_tick();
        push_event(KIND_TICK, ($urandom_range(3) == 0) ? 1023 : $urandom_range(0, 1023),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_directed();
        push_event(KIND_ALERT_ADJ, 0, UNIT_HOUR, 1'b1);       // below zero clamps to 0
        push_event(KIND_UNUSED, 1023, UNIT_UNUSED, 1'b1);
        push_event(KIND_ALERT_ADJ, 0, UNIT_UNUSED, 1'b0);     // no change, no re-arm
        push_event(KIND_ALERT_ADJ, 0, UNIT_SECOND, 1'b1);
        push_event(KIND_ALERT_ADJ, 0, UNIT_SECOND, 1'b0);
        push_event(KIND_ALERT_ADJ, 0, UNIT_MINUTE, 1'b0);
        push_event(KIND_ALERT_ADJ, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_ALERT_ADJ, 0, UNIT_MINUTE, 1'b1);
        push_event(KIND_ALERT_ADJ, 0, UNIT_SECOND, 1'b1);
        push_event(KIND_ALERT_ADJ, 0, UNIT_HOUR, 1'b1);
        push_event(KIND_ALERT_ADJ, 0, UNIT_SECOND, 1'b0);
        push_event(KIND_TICK, 1023, UNIT_HOUR, 1'b0);         // stopped: no add
        push_event(KIND_SCROLL_DOWN, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_SCROLL_UP, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_LAP, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_START_STOP, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_TICK, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_TICK, 1000, UNIT_HOUR, 1'b0);         // equal to alert: no fire
        push_event(KIND_TICK, 1, UNIT_HOUR, 1'b0);            // just above: fires
        push_event(KIND_TICK, 1023, UNIT_HOUR, 1'b0);
        push_event(KIND_LAP, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_ALERT_ADJ, 0, UNIT_SECOND, 1'b0);     // re-arm below time
        push_event(KIND_START_STOP, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_RESET, 0, UNIT_HOUR, 1'b0);
        push_event(KIND_TICK, 1023, UNIT_HOUR, 1'b0);
    endtask

    // walk the alert up towards the 99 h ceiling, then one second up or one minute down
    task automatic sweep_alert();
        int i;
        push_event(KIND_ALERT_ADJ, 0, UNIT_HOUR, 1'b1);
        push_event(KIND_ALERT_ADJ, 0, UNIT_HOUR, 1'b1);
        for (i = 0; i < 99; i++)
            push_event(KIND_ALERT_ADJ, 0, UNIT_HOUR, 1'b0);
        if ($urandom_range(1))
            push_event(KIND_ALERT_ADJ, 0, UNIT_SECOND, 1'b0);
        else
            push_event(KIND_ALERT_ADJ, 0, UNIT_MINUTE, 1'b1);
    endtask

    task automatic lap_session();
        int n;
        int i;
        if (!board.counting)
            push_event(KIND_START_STOP, 0, UNIT_HOUR, 1'b0);
        n = $urandom_range(1, 20);
        for (i = 0; i < n; i++) begin
            push_tick();
            push_event(KIND_LAP, $urandom_range(0, 1023), 2'($urandom_range(0, 3)), 1'b0);
        end
        n = $urandom_range(0, 12);
        for (i = 0; i < n; i++)
            push_event(KIND_SCROLL_UP, 0, UNIT_HOUR, 1'b0);
        n = $urandom_range(0, 6);
        for (i = 0; i < n; i++)
            push_event(KIND_SCROLL_DOWN, 0, UNIT_HOUR, 1'b1);
    endtask

    task automatic run_random();
        int r;
        int i;
        int n;
        sweep_alert();
        while (random_sent < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 20) begin
                push_noise();
            end else if (r < 50) begin
                if (!board.counting || $urandom_range(3) == 0)
                    push_event(KIND_START_STOP, 0, UNIT_HOUR, 1'b0);
                n = $urandom_range(3, 15);
                for (i = 0; i < n; i++)
                    push_tick();
            end else if (r < 75) begin
                lap_session();
            end else if (r < 90) begin
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++)
                    push_event(KIND_ALERT_ADJ, 0, 2'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1)));
            end else if (r < 97) begin
                push_event(KIND_RESET, $urandom_range(0, 1023), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1)));
            end else begin
                sweep_alert();
            end
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        evt_ch.valid <= 1'b0;
        evt_ch.kind <= KIND_TICK;
        evt_ch.elapsed_ms <= '0;
        evt_ch.adjust_unit <= UNIT_HOUR;
        evt_ch.adjust_down <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        evt_ch.valid <= 1'b0;
        while (board.expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.expected_status.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
